// ===== design/b64_pkg.sv =====
// Shared types, character constants and alphabet functions for the base64 codec.
package b64_pkg;

  localparam int unsigned B64_QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // One group handed from the front to the back.
  typedef struct packed {
    logic        dec;       // decode job: emit bytes, else characters
    logic [23:0] bits;      // gathered group, first item in the top bits
    logic [1:0]  nres_m1;   // results to emit, minus one
    logic [1:0]  ndata_m1;  // encode: characters carrying data, minus one
    logic        last;      // final group of the message
    logic        bad;       // error flag of the message so far
  } b64_job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64_sym_t;

  function automatic logic [7:0] to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      to_char = w + 8'd65;
    else if (v < 6'd52) to_char = w + 8'd71;
    else if (v < 6'd62) to_char = w - 8'd4;
    else if (v == 6'd62) to_char = CHAR_PLUS;
    else                to_char = CHAR_SLASH;
  endfunction

  function automatic b64_sym_t from_char(input logic [7:0] c);
    b64_sym_t   s;
    logic [7:0] d;
    s = '0;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'd65;
      s = '{valid: 1'b1, value: d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
      s = '{valid: 1'b1, value: d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      s = '{valid: 1'b1, value: d[5:0]};
    end else if (c == CHAR_PLUS) begin
      s = '{valid: 1'b1, value: 6'd62};
    end else if (c == CHAR_SLASH) begin
      s = '{valid: 1'b1, value: 6'd63};
    end
    from_char = s;
  endfunction

endpackage

// ===== design/b64_front.sv =====
// Front end: accepts input bytes, gathers groups, queues a job per full or final group.
module b64_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              q_full,
  output logic              push,
  output b64_pkg::b64_job_t job
);
  import b64_pkg::*;

  logic        mode_r, mode_nxt;
  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  gc_r, gc_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  b64_sym_t    sym;
  logic [5:0]  v;
  logic [23:0] bits_acc;
  logic [1:0]  pad_acc;
  logic        err_acc;
  logic [2:0]  gc_inc;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign sym       = from_char(in_byte);
  assign gc_inc    = {1'b0, gc_r} + 3'd1;

  always_comb begin
    mode_nxt = mode_r;
    bits_nxt = bits_r;
    gc_nxt   = gc_r;
    pad_nxt  = pad_r;
    err_nxt  = err_r;
    push     = 1'b0;
    job      = '0;
    v        = '0;
    bits_acc = bits_r;
    pad_acc  = pad_r;
    err_acc  = err_r;

    if (cfg_we) begin
      mode_nxt = cfg_wdata;
      bits_nxt = '0;
      gc_nxt   = '0;
      pad_nxt  = '0;
      err_nxt  = 1'b0;
    end else if (accept) begin
      if (mode_r == MODE_ENCODE) begin
        case (gc_r)
          2'd0:    bits_acc[23:16] = bits_r[23:16] | in_byte;
          2'd1:    bits_acc[15:8]  = bits_r[15:8]  | in_byte;
          default: bits_acc[7:0]   = bits_r[7:0]   | in_byte;
        endcase
        bits_nxt = bits_acc;
        gc_nxt   = gc_inc[1:0];
        if (gc_inc == 3'd3 || in_last) begin
          push         = 1'b1;
          job.dec      = 1'b0;
          job.bits     = bits_acc;
          job.nres_m1  = 2'd3;
          job.ndata_m1 = gc_inc[1:0];
          job.last     = in_last;
          job.bad      = 1'b0;
          bits_nxt     = '0;
          gc_nxt       = '0;
        end
      end else begin
        if (in_byte == CHAR_PAD) begin
          if (gc_r[1]) pad_acc = pad_r + 2'd1;
          else         err_acc = 1'b1;
        end else begin
          if (!sym.valid) err_acc = 1'b1;
          else            v = sym.value;
          if (pad_r != 2'd0) begin
            err_acc = 1'b1;
            v       = '0;
          end
        end
        case (gc_r)
          2'd0:    bits_acc[23:18] = bits_r[23:18] | v;
          2'd1:    bits_acc[17:12] = bits_r[17:12] | v;
          2'd2:    bits_acc[11:6]  = bits_r[11:6]  | v;
          default: bits_acc[5:0]   = bits_r[5:0]   | v;
        endcase
        bits_nxt = bits_acc;
        gc_nxt   = gc_inc[1:0];
        pad_nxt  = pad_acc;
        if (gc_r == 2'd3) begin
          if (pad_acc != 2'd0 && !in_last) err_acc = 1'b1;
          push        = 1'b1;
          job.dec     = 1'b1;
          job.bits    = bits_acc;
          job.nres_m1 = 2'd2 - pad_acc;
          job.last    = in_last;
          job.bad     = err_acc;
          bits_nxt    = '0;
          gc_nxt      = '0;
          pad_nxt     = '0;
        end else if (in_last) begin
          // incomplete final group: one zero byte flagged bad
          err_acc     = 1'b1;
          push        = 1'b1;
          job.dec     = 1'b1;
          job.nres_m1 = 2'd0;
          job.last    = 1'b1;
          job.bad     = 1'b1;
        end
        err_nxt = err_acc;
      end
      if (in_last) begin
        bits_nxt = '0;
        gc_nxt   = '0;
        pad_nxt  = '0;
        err_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      bits_r <= '0;
      gc_r   <= '0;
      pad_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      bits_r <= bits_nxt;
      gc_r   <= gc_nxt;
      pad_r  <= pad_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ===== design/b64_fifo.sv =====
// Small register queue of group jobs between front and back.
module b64_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             not_empty,
  output logic             full
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == FULL_CNT;
  assign head      = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + AW'(1);
    if (do_pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + AW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== design/b64_back.sv =====
// Back end: unpacks queued groups into one output result per cycle while the receiver is ready.
module b64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64_pkg::b64_job_t head,
  input  logic              q_not_empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_bad
);
  import b64_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       bad_r, bad_nxt;
  logic       load;
  logic       final_res;
  logic [5:0] sext;

  assign out_tvalid = vld_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_bad    = bad_r;
  assign load       = !vld_r || out_tready;
  assign final_res  = idx_r == head.nres_m1;

  always_comb begin
    case (idx_r)
      2'd0:    sext = head.bits[23:18];
      2'd1:    sext = head.bits[17:12];
      2'd2:    sext = head.bits[11:6];
      default: sext = head.bits[5:0];
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    bad_nxt  = bad_r;
    pop      = 1'b0;
    if (load) begin
      vld_nxt = q_not_empty;
      if (q_not_empty) begin
        if (head.dec) begin
          case (idx_r)
            2'd0:    byte_nxt = head.bits[23:16];
            2'd1:    byte_nxt = head.bits[15:8];
            default: byte_nxt = head.bits[7:0];
          endcase
          bad_nxt = head.bad;
        end else begin
          byte_nxt = (idx_r <= head.ndata_m1) ? to_char(sext) : CHAR_PAD;
          bad_nxt  = 1'b0;
        end
        last_nxt = head.last && final_res;
        if (final_res) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

endmodule

// ===== design/base64_stream_codec_top.sv =====
// Top level of the streaming base64 encoder/decoder.
//
// Usage:
//   Input stream: one byte per transaction on in_tdata; in_tlast marks the
//   final byte of a message. Output stream: one character (encode) or one
//   data byte (decode) per transaction on out_tdata; out_tlast marks the final
//   result of the message and out_tuser flags a bad message (decode only).
//   cfg_we/cfg_wdata write the mode (0 encode, 1 decode) and clear all group
//   state; write it only while the block is idle.
// Data path: the transaction that completes a group writes its job into the
//   job queue, and the back then loads its first result into the output register.
// Throughput: the front accepts one byte per cycle while the job queue has
//   room; the back emits one result per cycle while the receiver is ready.
//   Encode is bound by the output side at four characters per three bytes;
//   decode runs at one character per cycle while the receiver keeps up.
// Reset (rst_n low, synchronous): mode returns to encode, the queue empties
//   and the output register goes invalid.
// Receiver stall: the output register holds its result; the back stops
//   draining, the queue fills, and in_tready drops once it is full.
module base64_stream_codec_top #(
  parameter int unsigned QUEUE_DEPTH = b64_pkg::B64_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_out
  output logic       out_tuser,  // [0] bad_input
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import b64_pkg::*;

  localparam int unsigned JOB_W = $bits(b64_job_t);

  b64_job_t push_job;
  b64_job_t head_job;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;

  // Classify bytes and build group jobs.
  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  // Decouple the two sides so each can stall on its own.
  b64_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Drain one result per cycle into the output register while the receiver is ready.
  b64_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head_job),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_tdata),
    .out_last    (out_tlast),
    .out_bad     (out_tuser)
  );

endmodule

// ===== design/b64_checker.sv =====
// Port-level checks for the base64 codec, bound to the top level.
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Reset empties the queue, so the input side is ready right after.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // Nothing fresh can appear on the output right out of reset.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result without a preceding transaction");

endmodule

bind base64_stream_codec_top b64_checker u_b64_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming base64 codec: directed and random messages.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 225;
  localparam int QUIET_FROM     = 175;   // random items after which nobody idles
  localparam int SETTLE_CYCLES  = 8;     // pipeline depth plus margin
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // One transaction on the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } codec_result_t;

  // Damage applied to a well-formed base64 message.
  typedef enum int {
    FLAW_BAD_CHAR,
    FLAW_STRAY_PAD,
    FLAW_SHORT_TAIL,
    FLAW_EXTRA_CHAR
  } flaw_t;

  // Bit-exact codec predictor plus the queue of results it still awaits.
  class codec_scoreboard;
    logic          mode;
    logic [23:0]   acc_bits;
    int            acc_count;
    int            pad_seen;
    logic          msg_bad;
    codec_result_t awaited[$];
    int            checked;
    int            mismatches;

    function new();
      mode = MODE_ENCODE;
      clear_group();
      checked    = 0;
      mismatches = 0;
    endfunction

    function void clear_group();
      acc_bits  = '0;
      acc_count = 0;
      pad_seen  = 0;
      msg_bad   = 1'b0;
    endfunction

    function void set_mode(logic m);
      mode = m;
      clear_group();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    static function logic [7:0] sextet_to_ascii(logic [5:0] v);
      if (v < 6'd26) return 8'h41 + 8'(v);
      if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
      if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
      return (v == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    static function logic [5:0] ascii_to_sextet(logic [7:0] c, output logic ok);
      ok = 1'b1;
      if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
      if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd26);
      if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52);
      if (c == CHAR_PLUS) return 6'd62;
      if (c == CHAR_SLASH) return 6'd63;
      ok = 1'b0;
      return 6'd0;
    endfunction

    function void await_result(logic [7:0] d, logic l, logic b);
      codec_result_t r;
      r.data = d;
      r.last = l;
      r.bad  = b;
      awaited.push_back(r);
    endfunction

    function void encode_byte(logic [7:0] b, logic last);
      logic [23:0] shifted;
      if (acc_count > 2) acc_count = 0;
      acc_bits = acc_bits | (24'(b) << (16 - 8 * acc_count));
      acc_count++;
      if (acc_count == 3 || last) begin
        // acc_count + 1 characters carry data, the rest of the four are padding
        for (int i = 0; i < 4; i++) begin
          shifted = acc_bits >> (18 - 6 * i);
          await_result((i < acc_count + 1) ? sextet_to_ascii(shifted[5:0]) : CHAR_PAD,
                       last && (i == 3), 1'b0);
        end
        acc_bits  = '0;
        acc_count = 0;
      end
      if (last) clear_group();
    endfunction

    function void decode_char(logic [7:0] c, logic last);
      logic [5:0]  v;
      logic [5:0]  d;
      logic        ok;
      logic [23:0] shifted;
      int          nbytes;
      v = '0;
      if (c == CHAR_PAD) begin
        if (acc_count >= 2) pad_seen++;
        else msg_bad = 1'b1;
      end else begin
        d = ascii_to_sextet(c, ok);
        if (!ok) msg_bad = 1'b1;
        else v = d;
        // data after padding in the same group
        if (pad_seen != 0) begin
          msg_bad = 1'b1;
          v       = '0;
        end
      end
      acc_bits = acc_bits | (24'(v) << (18 - 6 * acc_count));
      acc_count++;
      if (acc_count == 4) begin
        nbytes = 3 - pad_seen;
        if (pad_seen != 0 && !last) msg_bad = 1'b1;
        for (int i = 0; i < nbytes; i++) begin
          shifted = acc_bits >> (16 - 8 * i);
          await_result(shifted[7:0], last && (i == nbytes - 1), msg_bad);
        end
        acc_bits  = '0;
        acc_count = 0;
        pad_seen  = 0;
      end else if (last) begin
        // message ended inside a group
        msg_bad = 1'b1;
        await_result(8'h00, 1'b1, 1'b1);
      end
      if (last) clear_group();
    endfunction

    function void note_input(logic [7:0] b, logic last);
      if (mode == MODE_ENCODE) encode_byte(b, last);
      else decode_char(b, last);
    endfunction

    function void check_output(logic [7:0] d, logic l, logic b);
      codec_result_t e;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result data=%h last=%b bad=%b", d, l, b);
      end else begin
        e = awaited.pop_front();
        if (e.data !== d || e.last !== l || e.bad !== b) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("ERROR: result %0d expected data=%h last=%b bad=%b, %s",
                     checked, e.data, e.last, e.bad,
                     $sformatf("got data=%h last=%b bad=%b", d, l, b));
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] in_byte
  logic       in_tlast;    // last_in
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;   // [7:0] out_byte
  logic       out_tlast;   // last_out
  logic       out_tuser;   // [0] bad_input
  logic       cfg_we;
  logic       cfg_wdata;

  codec_scoreboard codec = new();

  logic [7:0] msg[$];      // message staged for the input channel
  bit         tx_idle = 1'b0;
  bit         rx_idle = 1'b0;
  int         rx_hold = 0;
  int         quiet_cycles = 0;
  int         items_sent = 0;
  int         random_start = 0;
  int         messages = 0;
  int         mode_writes = 0;

  base64_stream_codec_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Receiver: hold out_tready low in random bursts while idling is on.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor both channels at the clock edge; a transaction is valid && ready there.
  // The watchdog counts edges that move nothing and ends a hung run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) codec.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready) codec.check_output(out_tdata, out_tlast, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("ERROR: watchdog, no transaction for %0d cycles, %0d results still awaited",
                   quiet_cycles, codec.pending());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Present one byte and hold it until the input transaction completes.
  task automatic push_byte(input logic [7:0] b, input logic l);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Send the staged message; tag the final byte with tlast when asked.
  task automatic send_message(input bit with_last);
    for (int i = 0; i < msg.size(); i++)
      push_byte(msg[i], with_last && (i == msg.size() - 1));
    if (with_last) messages++;
  endtask

  task automatic load_text(input string s);
    msg.delete();
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  // Drop valid, let the monitor note the last transaction, wait for every
  // awaited result, then let the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    @(posedge clk);
    while (codec.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    codec.set_mode(m);
    mode_writes++;
  endtask

  // Stage a decode message: whole groups of alphabet characters with optional
  // padding at the end, damaged now and then.
  task automatic build_decode_message();
    int    groups;
    int    pads;
    int    pos;
    flaw_t flaw;
    msg.delete();
    groups = $urandom_range(1, 3);
    repeat (groups * 4)
      msg.push_back(codec_scoreboard::sextet_to_ascii(6'($urandom_range(0, 63))));
    pads = $urandom_range(0, 2);
    for (int k = 0; k < pads; k++) msg[msg.size() - 1 - k] = CHAR_PAD;
    if ($urandom_range(0, 3) == 0) begin
      flaw = flaw_t'($urandom_range(0, 3));
      pos  = $urandom_range(0, msg.size() - 1);
      case (flaw)
        FLAW_BAD_CHAR: begin
          msg[pos] = 8'($urandom_range(0, 255));
        end
        FLAW_STRAY_PAD: begin
          msg[pos] = CHAR_PAD;
        end
        FLAW_SHORT_TAIL: begin
          repeat ($urandom_range(1, 3)) void'(msg.pop_back());
        end
        default: begin
          msg.insert(pos, 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  task automatic build_encode_message();
    msg.delete();
    repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int  phase;
    bit  quiet;
    logic m;

    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tlast   <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= MODE_ENCODE;
    rst_n      <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed encode in the reset mode: one, two and three byte messages,
    // extreme byte values, and a group that maps to '+' and '/'.
    msg.delete();
    msg.push_back(8'h00);
    send_message(1'b1);
    msg.delete();
    msg.push_back(8'hFF);
    msg.push_back(8'h00);
    send_message(1'b1);
    msg.delete();
    msg.push_back(8'hFB);
    msg.push_back(8'hFF);
    msg.push_back(8'hBF);
    send_message(1'b1);
    settle();

    write_mode(MODE_DECODE);
    // Clean group plus a single-padded final group.
    load_text("+/9zTWE=");
    send_message(1'b1);
    // Padded group mid-message, then padding at position 0, two characters
    // outside the alphabet and a clean one closing the group.
    load_text("TQ===");
    msg.push_back(8'h00);
    msg.push_back(8'hFF);
    msg.push_back(8'h41);
    send_message(1'b1);
    // Data after padding, then the message ends inside a group.
    load_text("QQ=BZ");
    send_message(1'b1);

    // Random phases: alternate the mode, send a few messages each, sometimes
    // leave a partial group behind for the next mode write to clear.
    random_start = items_sent;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      m     = (phase % 2 == 0) ? MODE_ENCODE : MODE_DECODE;
      quiet = (items_sent - random_start) >= QUIET_FROM;
      settle();
      tx_idle = !quiet && ($urandom_range(0, 3) != 0);
      rx_idle = !quiet && ($urandom_range(0, 3) != 0);
      write_mode(m);
      repeat ($urandom_range(2, 5)) begin
        if (m == MODE_ENCODE) build_encode_message();
        else build_decode_message();
        send_message(1'b1);
      end
      if ($urandom_range(0, 3) == 0) begin
        msg.delete();
        repeat ($urandom_range(1, 3)) begin
          if (m == MODE_ENCODE) msg.push_back(8'($urandom_range(0, 255)));
          else msg.push_back(codec_scoreboard::sextet_to_ascii(6'($urandom_range(0, 63))));
        end
        send_message(1'b0);
      end
      phase++;
    end

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    settle();

    $display("Run covered %0d input bytes in %0d messages over %0d mode writes.",
             items_sent, messages, mode_writes);
    $display("Checked %0d results, %0d mismatches.", codec.checked, codec.mismatches);
    if (codec.mismatches == 0 && codec.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
